// ----- sv/fru_multirecord_checker_core_macros.svh -----
// Assertion macros shared by the checker of the FRU multirecord checker core.
`ifndef FRU_MULTIRECORD_CHECKER_CORE_MACROS_SVH
`define FRU_MULTIRECORD_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define FMC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fmc assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define FMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fmc assertion failed");

`endif

// ----- sv/fmc_pkg.sv -----
// Types and constants of the FRU multirecord checker core.
package fmc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } fmc_phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_ERROR  = 2'd2
  } fmc_kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_HDR_SUM    = 3'd1,
    ST_BAD_FORMAT = 3'd2,
    ST_DATA_SUM   = 3'd3,
    ST_SHORT_HDR  = 3'd4,
    ST_SHORT_DATA = 3'd5
  } fmc_status_t;

  localparam logic [2:0] FORMAT_MASK  = 3'h7;
  localparam logic [2:0] FORMAT_V2    = 3'h2;
  localparam int         END_FLAG_BIT = 7;
  localparam int         HDR_BYTES    = 5;
  localparam logic [2:0] HDR_LAST_POS = 3'(HDR_BYTES - 1);

  typedef struct packed {
    fmc_phase_t  phase;
    logic [2:0]  header_pos;
    logic [7:0]  header_sum;
    logic [7:0]  data_sum;
    logic [7:0]  type_hold;
    logic        end_hold;
    logic [7:0]  length_hold;
    logic [7:0]  bytes_left;
    logic        fmt_bad;
  } fmc_state_t;

  typedef struct packed {
    logic        valid;
    fmc_kind_t   kind;
    logic [7:0]  data_byte;
    logic [7:0]  rec_type;
    logic [7:0]  rec_length;
    logic [3:0]  rec_index;
    logic        rec_end;
    fmc_status_t status;
    logic        area_done;
  } fmc_result_t;

endpackage

// ----- sv/fru_multirecord_checker_core.sv -----
// Top level of the FRU multirecord checker core: input and result registers.
// A beat is taken into the input register, and its result into the result register when it advances.
// Throughput: one byte per cycle unless out_stall holds a valid result; the running
// sums and counters of the parser step between the input and result registers set it.
// Reset clears both register stages and leaves the parser idle until a
// beat with first_byte arrives.
module fru_multirecord_checker_core import fmc_pkg::*; #(
  parameter int MAX_RECORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_rec_type,
  output logic [7:0]  out_rec_length,
  output logic [3:0]  out_rec_index,
  output logic        out_rec_end,
  output logic [2:0]  out_status,
  output logic        out_area_done
);

  localparam int CNT_BITS = $clog2(MAX_RECORDS + 1);
  localparam int CNT_W    = (CNT_BITS < 4) ? 4 : CNT_BITS;

  logic             a_valid_r;
  logic [7:0]       a_byte_r;
  logic             a_first_r;
  logic             a_last_r;
  fmc_state_t       state_r;
  fmc_state_t       state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  fmc_result_t      res_nxt;
  fmc_result_t      res_r;
  logic             advance;
  logic             in_take;

  assign advance  = a_valid_r && (!res_r.valid || !out_stall);
  assign in_stall = a_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  fmc_parse_step #(
    .MAX_RECORDS (MAX_RECORDS),
    .CNT_W       (CNT_W)
  ) u_step (
    .state_cur  (state_r),
    .count_cur  (count_r),
    .byte_in    (a_byte_r),
    .first_byte (a_first_r),
    .last_byte  (a_last_r),
    .state_nxt  (state_nxt),
    .count_nxt  (count_nxt),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r  <= in_byte_in;
      a_first_r <= in_first_byte;
      a_last_r  <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (advance) begin
      res_r <= res_nxt;
    end else if (!out_stall) begin
      res_r.valid <= 1'b0;
    end
  end

  assign out_valid      = res_r.valid;
  assign out_kind       = res_r.kind;
  assign out_data_byte  = res_r.data_byte;
  assign out_rec_type   = res_r.rec_type;
  assign out_rec_length = res_r.rec_length;
  assign out_rec_index  = res_r.rec_index;
  assign out_rec_end    = res_r.rec_end;
  assign out_status     = res_r.status;
  assign out_area_done  = res_r.area_done;

endmodule

// ----- sv/fmc_parse_step.sv -----
// Parser step logic: next parser state and the result caused by one byte.
module fmc_parse_step import fmc_pkg::*; #(
  parameter int MAX_RECORDS = 16,
  parameter int CNT_W       = 5
) (
  input  fmc_state_t       state_cur,
  input  logic [CNT_W-1:0] count_cur,
  input  logic [7:0]       byte_in,
  input  logic             first_byte,
  input  logic             last_byte,
  output fmc_state_t       state_nxt,
  output logic [CNT_W-1:0] count_nxt,
  output fmc_result_t      result
);

  fmc_state_t       st;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       hsum;
  logic [7:0]       dsum;
  logic [7:0]       left;
  logic             do_finish;
  logic             blank;
  logic [CNT_W:0]   cnt_inc;

  always_comb begin
    st = state_cur;
    cnt = count_cur;
    if (first_byte) begin
      st = '0;
      st.phase = PH_HEADER;
      cnt = '0;
    end
    state_nxt = st;
    count_nxt = cnt;
    result = '0;
    result.rec_index = cnt[3:0];
    do_finish = 1'b0;
    blank = 1'b0;
    hsum = st.header_sum + byte_in;
    dsum = st.data_sum + byte_in;
    left = st.bytes_left - 8'd1;
    cnt_inc = {1'b0, cnt} + (CNT_W+1)'(1);

    case (st.phase)
      PH_HEADER: begin
        state_nxt.header_sum = hsum;
        case (st.header_pos)
          3'd0: state_nxt.type_hold = byte_in;
          3'd1: begin
            state_nxt.end_hold = byte_in[END_FLAG_BIT];
            state_nxt.fmt_bad = (byte_in[2:0] & FORMAT_MASK) != FORMAT_V2;
          end
          3'd2: state_nxt.length_hold = byte_in;
          3'd3: state_nxt.data_sum = byte_in;
          default: ;
        endcase
        if (st.header_pos != HDR_LAST_POS) begin
          state_nxt.header_pos = st.header_pos + 3'd1;
          if (last_byte) begin
            result.valid = 1'b1;
            result.kind = KIND_ERROR;
            result.status = ST_SHORT_HDR;
            result.area_done = 1'b1;
            blank = 1'b1;
          end
        end else if (hsum != 8'd0) begin
          result.valid = 1'b1;
          result.kind = KIND_ERROR;
          result.status = ST_HDR_SUM;
          result.area_done = 1'b1;
        end else if (st.fmt_bad) begin
          result.valid = 1'b1;
          result.kind = KIND_ERROR;
          result.status = ST_BAD_FORMAT;
          result.area_done = 1'b1;
        end else if (st.length_hold == 8'd0) begin
          do_finish = 1'b1;
        end else if (last_byte) begin
          result.valid = 1'b1;
          result.kind = KIND_ERROR;
          result.status = ST_SHORT_DATA;
          result.area_done = 1'b1;
        end else begin
          state_nxt.phase = PH_DATA;
          state_nxt.bytes_left = st.length_hold;
        end
      end
      PH_DATA: begin
        state_nxt.data_sum = dsum;
        state_nxt.bytes_left = left;
        result.data_byte = byte_in;
        if (left == 8'd0) begin
          do_finish = 1'b1;
        end else begin
          result.valid = 1'b1;
          if (last_byte) begin
            result.kind = KIND_ERROR;
            result.status = ST_SHORT_DATA;
            result.area_done = 1'b1;
          end else begin
            result.kind = KIND_DATA;
          end
        end
      end
      default: ;
    endcase

    result.rec_type = state_nxt.type_hold;
    result.rec_length = state_nxt.length_hold;
    result.rec_end = state_nxt.end_hold;

    if (do_finish) begin
      result.valid = 1'b1;
      if (state_nxt.data_sum != 8'd0) begin
        result.kind = KIND_ERROR;
        result.status = ST_DATA_SUM;
        result.area_done = 1'b1;
      end else if (state_nxt.end_hold || cnt_inc >= (CNT_W+1)'(MAX_RECORDS)) begin
        result.kind = KIND_ACCEPT;
        result.area_done = 1'b1;
        count_nxt = cnt_inc[CNT_W-1:0];
      end else if (last_byte) begin
        result.kind = KIND_ERROR;
        result.status = ST_SHORT_HDR;
        result.area_done = 1'b1;
        count_nxt = cnt_inc[CNT_W-1:0];
        result.rec_index = cnt_inc[3:0];
        blank = 1'b1;
      end else begin
        result.kind = KIND_ACCEPT;
        count_nxt = cnt_inc[CNT_W-1:0];
        state_nxt = '0;
        state_nxt.phase = PH_HEADER;
      end
    end

    if (blank) begin
      result.rec_type = '0;
      result.rec_length = '0;
      result.rec_end = 1'b0;
    end
    if (result.area_done) begin
      state_nxt.phase = PH_IDLE;
    end
  end

endmodule

// ----- sv/fmc_checker.sv -----
// Port-level assertions for the FRU multirecord checker core and their binding.
`include "fru_multirecord_checker_core_macros.svh"

module fmc_checker import fmc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic [2:0] out_status,
  input logic       out_area_done
);

  `FMC_ASSERT_IMPLY(a_error_halts, out_valid && out_kind == KIND_ERROR, out_area_done)
  `FMC_ASSERT_IMPLY(a_error_has_status, out_valid && out_kind == KIND_ERROR, out_status != ST_OK)
  `FMC_ASSERT_IMPLY(a_good_is_ok, out_valid && out_kind != KIND_ERROR, out_status == ST_OK)
  `FMC_ASSERT_IMPLY(a_data_no_halt, out_valid && out_kind == KIND_DATA, !out_area_done)
  `FMC_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_data_byte))

endmodule

bind fru_multirecord_checker_core fmc_checker u_fmc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_status    (out_status),
  .out_area_done (out_area_done)
);
